/* hw/rtl/windowed_dft_bin_log_magnitude_unit_defines.svh */
// Assertion macros for the windowed DFT bin log-magnitude unit.
`ifndef WINDOWED_DFT_BIN_LOG_MAGNITUDE_UNIT_DEFINES_SVH
`define WINDOWED_DFT_BIN_LOG_MAGNITUDE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define WDB_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wdb assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define WDB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wdb assertion failed");

`endif

/* hw/rtl/wdb_pkg.sv */
// Constants, widths and the root table of the windowed DFT bin log-magnitude unit.
package wdb_pkg;

    localparam int MAX_WINDOW_DEF = 4096;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 20;
    localparam int LOG_W    = 8;
    localparam int ACC_W    = 45;
    localparam int MONO_W   = SAMPLE_W + 1;

    localparam int DIG_W    = 23;
    localparam int MUL_W    = DIG_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int M_W      = 2 * ACC_W;
    localparam int G2_W     = 2 * GAIN_W;
    localparam int ROOT_W   = 32;
    localparam int P_W      = G2_W + ROOT_W;
    localparam int ADD_W    = M_W + 2;
    localparam int LIM_SH   = 16;
    localparam int SCALE_SH = 19;
    localparam int D_W      = M_W + SCALE_SH;

    localparam int N_ROOTS      = 5;
    localparam int ROOT_IDX_W   = 3;
    localparam int STEP_W       = 5;
    localparam int G2_STEP      = 0;
    localparam int M_STEP_LAST  = 8;
    localparam int P_STEP_FIRST = 9;
    localparam int N_MUL_STEPS  = P_STEP_FIRST + 4 * N_ROOTS;
    localparam int LOG_MAX      = 255;

    // 2^(r/10) in Q1.31 for odd r
    function automatic logic [ROOT_W-1:0] root_coef(input logic [ROOT_IDX_W-1:0] idx);
        logic [ROOT_W-1:0] v;
        unique case (idx)
            3'd0:    v = 32'd2301615985;
            3'd1:    v = 32'd2643862496;
            3'd2:    v = 32'd3037000500;
            3'd3:    v = 32'd3488597478;
            3'd4:    v = 32'd4007346185;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/windowed_dft_bin_log_magnitude_unit.sv */
// Windowed single-bin DFT with log2 magnitude output, one shared multiplier.
// Sample transaction without last: MUL_S, MUL_C and ADD_C, then back to idle.
// Transaction with last: the accumulate states, a magnitude state, the multiply steps
// on the shared 24x24 multiplier, a check state, the search and an output state.
// The unit takes no new sample until it is back in idle; o_stall is high meanwhile.
// Synchronous active-low reset clears accumulators, window count and output valid.
module windowed_dft_bin_log_magnitude_unit
    import wdb_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic signed [COEF_W-1:0]   i_sin_coef,
    input  logic signed [COEF_W-1:0]   i_cos_coef,
    input  logic        [GAIN_W-1:0]   i_gain,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic        [LOG_W-1:0]    o_log_amp_tenths
);

`include "windowed_dft_bin_log_magnitude_unit_defines.svh"

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_S, S_MUL_C, S_ADD_C, S_ABS, S_FIN, S_CHK, S_SEARCH, S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ACC_W-1:0]        r_sacc, n_sacc;
    logic [ACC_W-1:0]        r_cacc, n_cacc;
    logic [STEP_W-1:0]       r_step, n_step;
    logic                    r_pv, n_pv;
    logic [ROOT_IDX_W-1:0]   r_ri, n_ri;
    logic [LOG_W-1:0]        r_cnt, n_cnt;
    logic                    r_ovalid, n_ovalid;
    logic [LOG_W-1:0]        r_odata, n_odata;

    logic [MONO_W-1:0]       r_mono;
    logic [COEF_W-1:0]       r_sin;
    logic [COEF_W-1:0]       r_cos;
    logic [GAIN_W-1:0]       r_gain;
    logic                    r_last;
    logic                    r_acc_en;
    logic [PROD_W-1:0]       r_prod;
    logic [STEP_W-1:0]       r_ptag;
    logic [ACC_W-1:0]        r_s;
    logic [ACC_W-1:0]        r_c;
    logic [G2_W-1:0]         r_g2;
    logic [ADD_W-1:0]        r_wacc;
    logic [M_W-1:0]          r_m;
    logic [P_W-1:0]          r_p [N_ROOTS];
    logic [D_W-1:0]          r_d;

    logic                    accept;
    logic                    cnt_open;
    logic [MONO_W-1:0]       mono_in;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [STEP_W-1:0]       m_idx;
    logic [STEP_W-1:0]       p_idx;
    logic [STEP_W-1:0]       t_idx;
    logic [STEP_W-1:0]       tp_idx;
    logic [1:0]              add_sh;
    logic [ADD_W-1:0]        prod_u;
    logic [ADD_W-1:0]        prod_sh;
    logic [ADD_W-1:0]        add_sum;
    logic                    amp_small;
    logic                    pass;

    function automatic logic [MUL_W-1:0] dig_acc(input logic [ACC_W-1:0] v, input logic hi);
        return hi ? MUL_W'(v[ACC_W-1:DIG_W]) : MUL_W'(v[DIG_W-1:0]);
    endfunction

    function automatic logic [MUL_W-1:0] dig_g2(input logic [G2_W-1:0] v, input logic hi);
        return hi ? MUL_W'(v[G2_W-1:DIG_W]) : MUL_W'(v[DIG_W-1:0]);
    endfunction

    function automatic logic [MUL_W-1:0] dig_root(input logic [ROOT_W-1:0] v, input logic hi);
        return hi ? MUL_W'(v[ROOT_W-1:DIG_W]) : MUL_W'(v[DIG_W-1:0]);
    endfunction

    function automatic logic [ACC_W-1:0] acc_abs(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    endfunction

    assign o_stall          = (r_state != S_IDLE);
    assign accept           = i_valid && (r_state == S_IDLE);
    assign cnt_open         = (r_count < CNT_W'(MAX_WINDOW));
    assign o_valid          = r_ovalid;
    assign o_log_amp_tenths = r_odata;

    assign mono_in = {i_left_sample[SAMPLE_W-1], i_left_sample}
                   + {i_right_sample[SAMPLE_W-1], i_right_sample};

    assign m_idx  = r_step - STEP_W'(1);
    assign p_idx  = r_step - STEP_W'(P_STEP_FIRST);
    assign t_idx  = r_ptag - STEP_W'(1);
    assign tp_idx = r_ptag - STEP_W'(P_STEP_FIRST);

    always_comb begin
        logic [ACC_W-1:0] x;
        x     = m_idx[2] ? r_c : r_s;
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL_S: begin
                mul_a = {{(MUL_W-MONO_W){r_mono[MONO_W-1]}}, r_mono};
                mul_b = {{(MUL_W-COEF_W){r_sin[COEF_W-1]}}, r_sin};
            end
            S_MUL_C: begin
                mul_a = {{(MUL_W-MONO_W){r_mono[MONO_W-1]}}, r_mono};
                mul_b = {{(MUL_W-COEF_W){r_cos[COEF_W-1]}}, r_cos};
            end
            S_FIN: begin
                if (r_step == STEP_W'(G2_STEP)) begin
                    mul_a = MUL_W'(r_gain);
                    mul_b = MUL_W'(r_gain);
                end else if (r_step <= STEP_W'(M_STEP_LAST)) begin
                    mul_a = dig_acc(x, m_idx[1]);
                    mul_b = dig_acc(x, m_idx[0]);
                end else if (r_step < STEP_W'(N_MUL_STEPS)) begin
                    mul_a = dig_g2(r_g2, p_idx[1]);
                    mul_b = dig_root(root_coef(p_idx[4:2]), p_idx[0]);
                end
            end
            default: ;
        endcase
    end

    assign mul_p = $signed(mul_a) * $signed(mul_b);

    assign add_sh = {1'b0, t_idx[1]} + {1'b0, t_idx[0]};
    assign prod_u = ADD_W'(r_prod[2*DIG_W-1:0]);

    always_comb begin
        unique case (add_sh)
            2'd0:    prod_sh = prod_u;
            2'd1:    prod_sh = prod_u << DIG_W;
            default: prod_sh = prod_u << (2 * DIG_W);
        endcase
    end

    assign add_sum   = r_wacc + prod_sh;
    assign amp_small = (r_gain == '0) || (r_m <= M_W'({r_g2, LIM_SH'(0)}));
    assign pass      = (r_d >= D_W'(r_p[r_ri]));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sacc   = r_sacc;
        n_cacc   = r_cacc;
        n_step   = r_step;
        n_pv     = 1'b0;
        n_ri     = r_ri;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MUL_S;
                    if (cnt_open) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            S_MUL_S: begin
                n_state = S_MUL_C;
            end
            S_MUL_C: begin
                if (r_acc_en) begin
                    n_sacc = r_sacc + r_prod[ACC_W-1:0];
                end
                n_state = S_ADD_C;
            end
            S_ADD_C: begin
                if (r_acc_en) begin
                    n_cacc = r_cacc + r_prod[ACC_W-1:0];
                end
                n_state = r_last ? S_ABS : S_IDLE;
            end
            S_ABS: begin
                n_sacc  = '0;
                n_cacc  = '0;
                n_count = '0;
                n_step  = '0;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_pv = (r_step < STEP_W'(N_MUL_STEPS));
                if (r_step == STEP_W'(N_MUL_STEPS)) begin
                    n_state = S_CHK;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_CHK: begin
                n_cnt   = '0;
                n_ri    = '0;
                n_state = amp_small ? S_DONE : S_SEARCH;
            end
            S_SEARCH: begin
                if (pass) begin
                    n_cnt = r_cnt + LOG_W'(1);
                    if (r_cnt == LOG_W'(LOG_MAX - 1)) begin
                        n_state = S_DONE;
                    end else if (r_ri == ROOT_IDX_W'(N_ROOTS - 1)) begin
                        n_ri = '0;
                    end else begin
                        n_ri = r_ri + ROOT_IDX_W'(1);
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_cnt;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sacc   <= '0;
            r_cacc   <= '0;
            r_step   <= '0;
            r_pv     <= 1'b0;
            r_ri     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_odata  <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sacc   <= n_sacc;
            r_cacc   <= n_cacc;
            r_step   <= n_step;
            r_pv     <= n_pv;
            r_ri     <= n_ri;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_odata  <= n_odata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mono   <= mono_in;
            r_sin    <= i_sin_coef;
            r_cos    <= i_cos_coef;
            r_gain   <= i_gain;
            r_last   <= i_last;
            r_acc_en <= cnt_open;
        end
        if (r_state == S_MUL_S || r_state == S_MUL_C || r_state == S_FIN) begin
            r_prod <= mul_p;
            r_ptag <= r_step;
        end
        if (r_state == S_ABS) begin
            r_s    <= acc_abs(r_sacc);
            r_c    <= acc_abs(r_cacc);
            r_wacc <= '0;
        end
        if (r_pv) begin
            if (r_ptag == STEP_W'(G2_STEP)) begin
                r_g2 <= r_prod[G2_W-1:0];
            end else if (r_ptag <= STEP_W'(M_STEP_LAST)) begin
                if (r_ptag == STEP_W'(M_STEP_LAST)) begin
                    r_m    <= add_sum[M_W-1:0];
                    r_wacc <= '0;
                end else begin
                    r_wacc <= add_sum;
                end
            end else begin
                if (t_idx[1:0] == 2'b11) begin
                    r_p[tp_idx[4:2]] <= add_sum[P_W-1:0];
                    r_wacc           <= '0;
                end else begin
                    r_wacc <= add_sum;
                end
            end
        end
        if (r_state == S_CHK) begin
            r_d <= {r_m, SCALE_SH'(0)};
        end else if (r_state == S_SEARCH && pass && r_ri == ROOT_IDX_W'(N_ROOTS - 1)) begin
            r_d <= r_d >> 1;
        end
    end

    `WDB_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `WDB_ASSERT_IMPLY(a_result_from_done, $rose(o_valid), $past(r_state == S_DONE))
    `WDB_ASSERT_IMPLY(a_window_bound, r_state != S_ABS, r_count <= CNT_W'(MAX_WINDOW))
    `WDB_ASSERT_IMPLY(a_search_bound, r_state == S_SEARCH, r_cnt != LOG_W'(LOG_MAX))

endmodule
